### rtl/mep_pkg.sv
// ----------------------------------------------------------------------------
// mep_pkg
// Shared constants, types and helpers of the escape-time pixel evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package mep_pkg;

  // Field and register widths
  localparam int PixW    = 10;
  localparam int CoordW  = 32;
  localparam int StepW   = 31;
  localparam int LimitW  = 16;
  localparam int CountW  = 17;
  localparam int ColorW  = 5;
  localparam int CfgIdxW = 2;

  // Fixed-point format and geometry
  localparam int FracBits   = 28;
  localparam int SidePixels = 1024;

  // Shared multiplier and iteration word sizes
  localparam int MulW  = 32;
  localparam int ProdW = 2 * MulW;
  localparam int SqW   = ProdW - FracBits;   // scaled square
  localparam int AccW  = SqW + 2;            // sums of squares and coordinates
  localparam int ZW    = 34;                 // stored x and y
  localparam int CSumW = PixW + StepW + 2;   // start + pixel * step

  localparam logic [SqW:0] EscapeBound = (SqW + 1)'(64'd4 << FracBits);

  localparam logic signed [CSumW-1:0] CoordMax = CSumW'({1'b0, {(CoordW - 1){1'b1}}});
  localparam logic signed [CSumW-1:0] CoordMin = -CoordMax - CSumW'(1);

  localparam logic [ColorW-1:0] PaletteLast = ColorW'(23);
  localparam logic [ColorW-1:0] InsideColor = ColorW'(24);

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgLeft  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgTop   = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] CfgStep  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgLimit = CfgIdxW'(3);

  // Register reset values
  localparam logic signed [CoordW-1:0] LeftReset  = -CoordW'(32'sd536870912);
  localparam logic signed [CoordW-1:0] TopReset   = CoordW'(32'sd536870912);
  localparam logic [StepW-1:0]         StepReset  = StepW'(1048576);
  localparam logic [LimitW-1:0]        LimitReset = LimitW'(256);

  typedef enum logic [2:0] {
    MulNone,
    MulCol,
    MulRow,
    MulXy,
    MulXx,
    MulYy
  } mul_sel_e;

  typedef struct packed {
    logic     load_px;
    mul_sel_e mul_sel;
    logic     set_cre;
    logic     set_cim;
    logic     run_round;
    logic     set_y;
    logic     set_x2;
    logic     fin_esc;
    logic     fin_lim;
  } dp_cmd_t;

  typedef struct packed {
    logic escaped;
    logic at_limit;
  } dp_stat_t;

  // Clip an exact coordinate sum to the signed register format.
  function automatic logic signed [CoordW-1:0] sat_coord(input logic signed [CSumW-1:0] v);
    logic signed [CoordW-1:0] r;
    if (v > CoordMax) begin
      r = CoordMax[CoordW-1:0];
    end else if (v < CoordMin) begin
      r = CoordMin[CoordW-1:0];
    end else begin
      r = v[CoordW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/mep_mul.sv
// ----------------------------------------------------------------------------
// mep_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module mep_mul (
  input  logic                       clk_i,
  input  logic [mep_pkg::MulW-1:0]   a_i,
  input  logic [mep_pkg::MulW-1:0]   b_i,
  output logic [mep_pkg::ProdW-1:0]  p_o
);
  import mep_pkg::*;

  logic [ProdW-1:0] p_q;

  always_ff @(posedge clk_i) begin
    p_q <= ProdW'(a_i) * ProdW'(b_i);
  end

  assign p_o = p_q;

endmodule

`default_nettype wire

### rtl/mep_dp.sv
// ----------------------------------------------------------------------------
// mep_dp
// Datapath: point setup, z = z^2 + c rounds on one shared multiplier,
// round and palette counters, result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module mep_dp (
  input  logic                              clk_i,
  input  mep_pkg::dp_cmd_t                  cmd_i,
  output mep_pkg::dp_stat_t                 stat_o,
  input  logic [mep_pkg::PixW-1:0]          column_i,
  input  logic [mep_pkg::PixW-1:0]          row_i,
  input  logic signed [mep_pkg::CoordW-1:0] left_i,
  input  logic signed [mep_pkg::CoordW-1:0] top_i,
  input  logic [mep_pkg::StepW-1:0]         step_i,
  input  logic [mep_pkg::LimitW-1:0]        limit_i,
  output logic [mep_pkg::CountW-1:0]        escape_count_o,
  output logic [mep_pkg::ColorW-1:0]        color_index_o
);
  import mep_pkg::*;

  logic [PixW-1:0]          col_q, row_q, col_c, row_c;
  logic signed [CoordW-1:0] cre_q, cim_q;
  logic signed [ZW-1:0]     x_q, y_q, x_abs, y_abs;
  logic [SqW-1:0]           x2_q, y2;
  logic                     xy_neg_q;
  logic [LimitW-1:0]        round_q;
  logic [ColorW-1:0]        pal_q, pal_last_q;
  logic [CountW-1:0]        count_q;
  logic [ColorW-1:0]        color_q;

  logic [MulW-1:0]          mul_a, mul_b, x_mag, y_mag;
  logic [ProdW-1:0]         prod;
  logic signed [CSumW-1:0]  re_sum, im_sum;
  logic signed [AccW-1:0]   xy_q_ext, xy_term, y_new, x_new;
  logic                     xy_adj;
  logic [SqW:0]             mag_sum;

  // Clamp pixel indexes to the picture side
  always_comb begin
    col_c = column_i;
    row_c = row_i;
    if (32'(column_i) >= 32'(SidePixels)) col_c = PixW'(SidePixels - 1);
    if (32'(row_i) >= 32'(SidePixels))    row_c = PixW'(SidePixels - 1);
  end

  assign x_abs = x_q[ZW-1] ? -x_q : x_q;
  assign y_abs = y_q[ZW-1] ? -y_q : y_q;
  assign x_mag = x_abs[MulW-1:0];
  assign y_mag = y_abs[MulW-1:0];

  always_comb begin
    case (cmd_i.mul_sel)
      MulCol: begin
        mul_a = MulW'(col_q);
        mul_b = MulW'(step_i);
      end
      MulRow: begin
        mul_a = MulW'(row_q);
        mul_b = MulW'(step_i);
      end
      MulXy: begin
        mul_a = x_mag;
        mul_b = y_mag;
      end
      MulXx: begin
        mul_a = x_mag;
        mul_b = x_mag;
      end
      MulYy: begin
        mul_a = y_mag;
        mul_b = y_mag;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  mep_mul u_mul (
    .clk_i (clk_i),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (prod)
  );

  // Point setup: exact sums, then clip
  assign re_sum = CSumW'(left_i) + $signed({2'b00, prod[PixW+StepW-1:0]});
  assign im_sum = CSumW'(top_i)  - $signed({2'b00, prod[PixW+StepW-1:0]});

  // 2*x*y with floor rounding, then add c_im
  assign xy_q_ext = $signed(AccW'(prod[ProdW-1:FracBits-1]));
  assign xy_adj   = xy_neg_q & (|prod[FracBits-2:0]);
  assign xy_term  = xy_neg_q ? -(xy_q_ext + AccW'(xy_adj)) : xy_q_ext;
  assign y_new    = xy_term + AccW'(cim_q);

  // The product register holds y*y once a round has run
  assign y2      = (round_q == '0) ? '0 : prod[ProdW-1:FracBits];
  assign x_new   = $signed(AccW'(x2_q)) - $signed(AccW'(y2)) + AccW'(cre_q);
  assign mag_sum = (SqW + 1)'(x2_q) + (SqW + 1)'(y2);

  assign stat_o.escaped  = (round_q != '0) && (mag_sum > EscapeBound);
  assign stat_o.at_limit = (round_q == limit_i);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_px) begin
      col_q <= col_c;
      row_q <= row_c;
    end
    if (cmd_i.set_cre) begin
      cre_q <= sat_coord(re_sum);
    end
    if (cmd_i.set_cim) begin
      cim_q   <= sat_coord(im_sum);
      x_q     <= '0;
      y_q     <= '0;
      x2_q    <= '0;
      round_q <= '0;
      pal_q   <= '0;
    end
    if (cmd_i.run_round) begin
      x_q        <= x_new[ZW-1:0];
      xy_neg_q   <= x_q[ZW-1] ^ y_q[ZW-1];
      round_q    <= round_q + LimitW'(1);
      pal_last_q <= pal_q;
      // Palette index advances on every second round
      if (round_q[0]) begin
        pal_q <= (pal_q == PaletteLast) ? '0 : pal_q + ColorW'(1);
      end
    end
    if (cmd_i.set_y) begin
      y_q <= y_new[ZW-1:0];
    end
    if (cmd_i.set_x2) begin
      x2_q <= prod[ProdW-1:FracBits];
    end
    if (cmd_i.fin_esc) begin
      count_q <= CountW'(round_q - LimitW'(1));
      color_q <= pal_last_q;
    end
    if (cmd_i.fin_lim) begin
      count_q <= CountW'(limit_i) + CountW'(1);
      color_q <= InsideColor;
    end
  end

  assign escape_count_o = count_q;
  assign color_index_o  = color_q;

endmodule

`default_nettype wire

### rtl/mep_ctrl.sv
// ----------------------------------------------------------------------------
// mep_ctrl
// Sequencer: point setup, then rounds through S_XY, S_Y and S_SQ until escape or limit.
// ----------------------------------------------------------------------------
`default_nettype none

module mep_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  output logic               done_o,
  input  mep_pkg::dp_stat_t  stat_i,
  output mep_pkg::dp_cmd_t   cmd_o
);
  import mep_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_COL,
    S_ROW,
    S_CIM,
    S_XY,
    S_Y,
    S_SQ
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, done_q, done_d;

  always_comb begin
    cmd_o   = '0;
    cmd_o.mul_sel = MulNone;
    state_d = state_q;
    done_d  = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load_px = 1'b1;
          state_d       = S_COL;
        end
      end
      S_COL: begin
        cmd_o.mul_sel = MulCol;
        state_d       = S_ROW;
      end
      S_ROW: begin
        cmd_o.set_cre = 1'b1;
        cmd_o.mul_sel = MulRow;
        state_d       = S_CIM;
      end
      S_CIM: begin
        cmd_o.set_cim = 1'b1;
        state_d       = S_XY;
      end
      S_XY: begin
        if (stat_i.escaped) begin
          cmd_o.fin_esc = 1'b1;
          done_d        = 1'b1;
          state_d       = S_IDLE;
        end else if (stat_i.at_limit) begin
          cmd_o.fin_lim = 1'b1;
          done_d        = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd_o.run_round = 1'b1;
          cmd_o.mul_sel   = MulXy;
          state_d         = S_Y;
        end
      end
      S_Y: begin
        cmd_o.set_y   = 1'b1;
        cmd_o.mul_sel = MulXx;
        state_d       = S_SQ;
      end
      S_SQ: begin
        cmd_o.set_x2  = 1'b1;
        cmd_o.mul_sel = MulYy;
        state_d       = S_XY;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= (state_d != S_IDLE);
      done_q  <= done_d;
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result strobe while busy");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted pixel did not start");

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");
`endif

endmodule

`default_nettype wire

### rtl/mandelbrot_escape_pixel.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel
// Escape-time evaluator for one pixel of a Mandelbrot view in Q4.28.
// ----------------------------------------------------------------------------
// Usage:
//   Program left_start, top_start, step and iter_limit through the write
//   port (cfg_we_i, cfg_idx_i, cfg_wdata_i) while the block is idle.
//   Present a pixel on column_i/row_i with start_i; the beat is taken at an
//   edge where start_i is high and busy_o is low. busy_o stays high until
//   the result is out.
//   The result beat (escape_count_o, color_index_o) is shown for exactly
//   one cycle with done_o; the receiver cannot stall it.
// Sequence:
//   Point setup (column*step, row*step, clip), then rounds on the one
//   shared 32x32 multiplier (x*y, x*x, y*y); before each round the
//   sequencer decides between escape, limit and another round. One
//   pixel is in flight at a time, and a new one may be started in the
//   cycle that done_o is shown.
// Reset:
//   rst_ni clears the sequencer and loads the register reset values.
// ----------------------------------------------------------------------------
`default_nettype none

module mandelbrot_escape_pixel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [mep_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [mep_pkg::CoordW-1:0]    cfg_wdata_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [mep_pkg::PixW-1:0]      column_i,
  input  logic [mep_pkg::PixW-1:0]      row_i,
  output logic                          done_o,
  output logic [mep_pkg::CountW-1:0]    escape_count_o,
  output logic [mep_pkg::ColorW-1:0]    color_index_o
);
  import mep_pkg::*;

  logic signed [CoordW-1:0] left_q, top_q;
  logic [StepW-1:0]         step_q;
  logic [LimitW-1:0]        limit_q;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Configuration registers: write-only, taken on any enabled edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= LeftReset;
      top_q   <= TopReset;
      step_q  <= StepReset;
      limit_q <= LimitReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLeft:  left_q  <= $signed(cfg_wdata_i);
        CfgTop:   top_q   <= $signed(cfg_wdata_i);
        CfgStep:  step_q  <= cfg_wdata_i[StepW-1:0];
        CfgLimit: limit_q <= cfg_wdata_i[LimitW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer: hold setup, advance rounds, drop to idle on escape or limit
  mep_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .done_o  (done_o),
    .stat_i  (stat),
    .cmd_o   (cmd)
  );

  // Datapath with the shared multiplier and result registers
  mep_dp u_dp (
    .clk_i          (clk_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .column_i       (column_i),
    .row_i          (row_i),
    .left_i         (left_q),
    .top_i          (top_q),
    .step_i         (step_q),
    .limit_i        (limit_q),
    .escape_count_o (escape_count_o),
    .color_index_o  (color_index_o)
  );

`ifndef SYNTH
  a_color_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (color_index_o <= InsideColor)) else $error("palette index out of range");

  a_escape_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (color_index_o != InsideColor)) |-> (escape_count_o < CountW'(limit_q)))
    else $error("escaped count not below limit");
`endif

endmodule

`default_nettype wire
